[design/bkl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkl_pkg: shared types and constants for the bounded keyed list
// Widths, command and status codes, the entry and probe records, the per-cell
// control bundle and the sequencer states.
// ----------------------------------------------------------------------------
package bkl_pkg;

  // list size and field widths
  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int PRICE_W  = 24;
  localparam int TAX_W    = 14;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;
  localparam int POS_W    = 5;
  localparam int LIMIT_W  = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CMP_W-1:0]   cmp_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  // limit register after reset
  localparam limit_t LIMIT_RESET = limit_t'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FOUND     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [TAX_W-1:0]   tax;
  } entry_t;

  // match record carried from cell to cell
  typedef struct packed {
    logic               hit;
    idx_t               idx;
    logic [PRICE_W-1:0] price;
    logic [TAX_W-1:0]   tax;
  } probe_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             wr;
    idx_t             wr_idx;
    entry_t           wdata;
    logic             shift;
    idx_t             hit_idx;
    logic             first_hit;
    logic [KEY_W-1:0] key;
    cnt_t             count;
  } cell_ctrl_t;

endpackage

[design/bkl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkl_cell: one slot of the keyed list
// Holds one entry, loads it on insert or from its upper neighbor when a
// delete closes the gap, and advances the match probe by one slot a cycle.
// ----------------------------------------------------------------------------
module bkl_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  bkl_pkg::idx_t       cell_idx,
  input  bkl_pkg::cell_ctrl_t ctrl,
  input  bkl_pkg::entry_t     next_entry,
  output bkl_pkg::entry_t     entry,
  input  logic                live_in,
  input  bkl_pkg::probe_t     probe_in,
  output logic                live_out,
  output bkl_pkg::probe_t     probe_out
);

  bkl_pkg::entry_t entry_r, entry_nxt;
  bkl_pkg::probe_t probe_r, probe_nxt;
  logic            live_r;
  logic            held;
  logic            take;

  // entry load: insert at this slot, or shift down past the removed slot
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.wr && (ctrl.wr_idx == cell_idx)) begin
      entry_nxt = ctrl.wdata;
    end else if (ctrl.shift && (cell_idx >= ctrl.hit_idx)) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // probe step: search keeps the first hit, delete keeps the last
  assign held = (bkl_pkg::cnt_t'(cell_idx) < ctrl.count);
  assign take = live_in && held && (entry_r.key == ctrl.key) &&
                (!ctrl.first_hit || !probe_in.hit);

  always_comb begin
    probe_nxt = probe_in;
    if (take) begin
      probe_nxt.hit   = 1'b1;
      probe_nxt.idx   = cell_idx;
      probe_nxt.price = entry_r.price;
      probe_nxt.tax   = entry_r.tax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_in;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
  end

  assign entry     = entry_r;
  assign live_out  = live_r;
  assign probe_out = probe_r;

endmodule

[design/bounded_keyed_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_keyed_list_top: compact keyed list with insert, delete and search
// A row of slot cells holds the entries; a sequencer drives inserts, sends a
// match probe down the row, and compacts the row after a delete.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   command, key, price, tax rate
//   out      output     out_valid / out_ready status, position, price, tax,
//                                             entries held
//   cfg      input      cfg_we, no wait       capacity limit
//
// Insert and the unused command go from idle to done; delete and search pass
// through launch and a scan paced by the probe walking one slot per cycle.
// Reset clears the entry count and sets the limit to 16; slot contents are
// not cleared and are never read until written.
// The result sits in an output register, so the next beat is taken while the
// last result waits; a result that finds the output still full waits for it.
// ----------------------------------------------------------------------------
module bounded_keyed_list_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bkl_pkg::CMD_W-1:0]     in_command,
  input  logic [bkl_pkg::KEY_W-1:0]     in_key,
  input  logic [bkl_pkg::PRICE_W-1:0]   in_price,
  input  logic [bkl_pkg::TAX_W-1:0]     in_tax_rate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bkl_pkg::STAT_W-1:0]    out_status,
  output logic [bkl_pkg::POS_W-1:0]     out_position,
  output logic [bkl_pkg::PRICE_W-1:0]   out_price,
  output logic [bkl_pkg::TAX_W-1:0]     out_tax_rate,
  output logic [bkl_pkg::POS_W-1:0]     out_entries_held,
  input  logic                          cfg_we,
  input  logic [bkl_pkg::LIMIT_W-1:0]   cfg_capacity_limit
);

  localparam int LAST = bkl_pkg::CAPACITY - 1;

  bkl_pkg::state_t     state_r, state_nxt;
  bkl_pkg::cnt_t       count_r, count_nxt;
  bkl_pkg::limit_t     limit_r;
  logic [bkl_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [bkl_pkg::KEY_W-1:0] key_r, key_nxt;

  logic [bkl_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  bkl_pkg::pos_t               res_pos_r, res_pos_nxt;
  logic [bkl_pkg::PRICE_W-1:0] res_price_r, res_price_nxt;
  logic [bkl_pkg::TAX_W-1:0]   res_tax_r, res_tax_nxt;
  bkl_pkg::pos_t               res_held_r, res_held_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [bkl_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  bkl_pkg::pos_t               out_pos_r, out_pos_nxt;
  logic [bkl_pkg::PRICE_W-1:0] out_price_r, out_price_nxt;
  logic [bkl_pkg::TAX_W-1:0]   out_tax_r, out_tax_nxt;
  bkl_pkg::pos_t               out_held_r, out_held_nxt;

  bkl_pkg::cell_ctrl_t ctrl;
  bkl_pkg::entry_t     entry_w [bkl_pkg::CAPACITY];
  bkl_pkg::entry_t     next_w  [bkl_pkg::CAPACITY];
  bkl_pkg::probe_t     pin_w   [bkl_pkg::CAPACITY];
  bkl_pkg::probe_t     pout_w  [bkl_pkg::CAPACITY];
  logic [bkl_pkg::CAPACITY-1:0] lin_w, lout_w;

  logic            accept;
  logic            out_free;
  logic            room;
  logic            last_live;
  bkl_pkg::probe_t last_probe;

  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign last_live  = lout_w[LAST];
  assign last_probe = pout_w[LAST];
  assign room = (bkl_pkg::cmp_t'(count_r) < bkl_pkg::cmp_t'(limit_r)) &&
                (bkl_pkg::cmp_t'(count_r) < bkl_pkg::cmp_t'(bkl_pkg::CAPACITY));

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bkl_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_command == bkl_pkg::CMD_DELETE) ||
              (in_command == bkl_pkg::CMD_SEARCH)) begin
            state_nxt = bkl_pkg::ST_LAUNCH;
          end else begin
            state_nxt = bkl_pkg::ST_DONE;
          end
        end
      end
      bkl_pkg::ST_LAUNCH: state_nxt = bkl_pkg::ST_SCAN;
      bkl_pkg::ST_SCAN: begin
        if (last_live) begin
          state_nxt = bkl_pkg::ST_DONE;
        end
      end
      bkl_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bkl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bkl_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: cell control, count, staged result, output register
  always_comb begin
    in_ready       = (state_r == bkl_pkg::ST_IDLE);
    ctrl.wr        = 1'b0;
    ctrl.wr_idx    = bkl_pkg::idx_t'(count_r);
    ctrl.wdata     = '{key: in_key, price: in_price, tax: in_tax_rate};
    ctrl.shift     = 1'b0;
    ctrl.hit_idx   = last_probe.idx;
    ctrl.first_hit = (cmd_r == bkl_pkg::CMD_SEARCH);
    ctrl.key       = key_r;
    ctrl.count     = count_r;

    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_price_nxt  = res_price_r;
    res_tax_nxt    = res_tax_r;
    res_held_nxt   = res_held_r;

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_price_nxt  = out_price_r;
    out_tax_nxt    = out_tax_r;
    out_held_nxt   = out_held_r;

    unique case (state_r)
      bkl_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_command;
          key_nxt       = in_key;
          res_pos_nxt   = '0;
          res_price_nxt = '0;
          res_tax_nxt   = '0;
          res_held_nxt  = bkl_pkg::pos_t'(count_r);
          res_status_nxt = bkl_pkg::STAT_NOT_FOUND;
          if (in_command == bkl_pkg::CMD_INSERT) begin
            if (room) begin
              ctrl.wr        = 1'b1;
              count_nxt      = count_r + bkl_pkg::cnt_t'(1);
              res_status_nxt = bkl_pkg::STAT_INSERTED;
              res_held_nxt   = bkl_pkg::pos_t'(count_r + bkl_pkg::cnt_t'(1));
            end else begin
              res_status_nxt = bkl_pkg::STAT_FULL;
            end
          end
        end
      end
      bkl_pkg::ST_LAUNCH: begin
      end
      bkl_pkg::ST_SCAN: begin
        if (last_live && last_probe.hit) begin
          if (cmd_r == bkl_pkg::CMD_SEARCH) begin
            res_status_nxt = bkl_pkg::STAT_FOUND;
            res_pos_nxt    = bkl_pkg::pos_t'(bkl_pkg::cnt_t'(last_probe.idx) +
                                             bkl_pkg::cnt_t'(1));
            res_price_nxt  = last_probe.price;
            res_tax_nxt    = last_probe.tax;
          end else begin
            // delete: close the gap from the last hit upward
            ctrl.shift     = 1'b1;
            count_nxt      = count_r - bkl_pkg::cnt_t'(1);
            res_status_nxt = bkl_pkg::STAT_REMOVED;
            res_held_nxt   = bkl_pkg::pos_t'(count_r - bkl_pkg::cnt_t'(1));
          end
        end
      end
      bkl_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase

    // output register: take the staged result when the slot is free
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == bkl_pkg::ST_DONE) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_pos_nxt    = res_pos_r;
      out_price_nxt  = res_price_r;
      out_tax_nxt    = res_tax_r;
      out_held_nxt   = res_held_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bkl_pkg::ST_IDLE;
      count_r     <= '0;
      limit_r     <= bkl_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_capacity_limit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_price_r  <= res_price_nxt;
    res_tax_r    <= res_tax_nxt;
    res_held_r   <= res_held_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_price_r  <= out_price_nxt;
    out_tax_r    <= out_tax_nxt;
    out_held_r   <= out_held_nxt;
  end

  // row of slot cells
  for (genvar i = 0; i < bkl_pkg::CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lin_w[i] = (state_r == bkl_pkg::ST_LAUNCH);
      assign pin_w[i] = '0;
    end else begin : g_link
      assign lin_w[i] = lout_w[i-1];
      assign pin_w[i] = pout_w[i-1];
    end
    if (i == LAST) begin : g_tail
      assign next_w[i] = entry_w[i];
    end else begin : g_next
      assign next_w[i] = entry_w[i+1];
    end

    bkl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (bkl_pkg::idx_t'(i)),
      .ctrl       (ctrl),
      .next_entry (next_w[i]),
      .entry      (entry_w[i]),
      .live_in    (lin_w[i]),
      .probe_in   (pin_w[i]),
      .live_out   (lout_w[i]),
      .probe_out  (pout_w[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_position     = out_pos_r;
  assign out_price        = out_price_r;
  assign out_tax_rate     = out_tax_r;
  assign out_entries_held = out_held_r;

endmodule

[test/bounded_keyed_list_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_keyed_list_top_tb: self-checking bench for the bounded keyed list
// A short table of directed beats covers the empty list, the field extremes,
// duplicate keys, the unused command and the compacting delete. Random phases
// follow, one capacity limit per phase: 0, 31, limits under the entries held,
// and the reset value. An internal shadow of the list predicts each result
// not typed in the table. Both channels stall at random, some phases at full rate.
// ----------------------------------------------------------------------------
module bounded_keyed_list_top_tb;
  import bkl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT   = 2000;   // cycles with no beat on either side
  localparam int TAIL_CYCLES   = CAPACITY + 8;
  localparam int PHASES        = 10;
  localparam int PHASE_BEATS   = 48;
  localparam int POOL_SIZE     = 6;
  localparam logic [TAX_W-1:0] TAX_MAX = 14'd10000;

  typedef struct packed {
    status_t            status;
    pos_t               position;
    logic [PRICE_W-1:0] price;
    logic [TAX_W-1:0]   tax_rate;
    pos_t               held;
  } list_result_t;

  // one input beat, with a typed-in result where it is obvious
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [TAX_W-1:0]   tax_rate;
    logic               typed;
    list_result_t       want;
  } list_beat_t;

  localparam list_result_t NO_WANT = '0;

  list_beat_t dir_table [17] = '{
    // empty list after reset
    '{CMD_SEARCH, 32'h0,        24'h0,      14'h0,    1'b1,
      '{STAT_NOT_FOUND, 5'd0, 24'h0, 14'h0, 5'd0}},
    '{CMD_DELETE, 32'hFFFFFFFF, 24'h0,      14'h0,    1'b1,
      '{STAT_NOT_FOUND, 5'd0, 24'h0, 14'h0, 5'd0}},
    '{CMD_UNUSED, 32'h5,        24'h7,      14'h9,    1'b1,
      '{STAT_NOT_FOUND, 5'd0, 24'h0, 14'h0, 5'd0}},
    // extremes, duplicate key, tax rate over range
    '{CMD_INSERT, 32'h0,        24'h0,      14'h0,    1'b1,
      '{STAT_INSERTED, 5'd0, 24'h0, 14'h0, 5'd1}},
    '{CMD_INSERT, 32'hFFFFFFFF, 24'hFFFFFF, TAX_MAX,  1'b1,
      '{STAT_INSERTED, 5'd0, 24'h0, 14'h0, 5'd2}},
    '{CMD_INSERT, 32'hFFFFFFFF, 24'h000123, 14'h3FFF, 1'b1,
      '{STAT_INSERTED, 5'd0, 24'h0, 14'h0, 5'd3}},
    '{CMD_SEARCH, 32'hFFFFFFFF, 24'h0,      14'h0,    1'b1,
      '{STAT_FOUND, 5'd2, 24'hFFFFFF, TAX_MAX, 5'd3}},
    // alternating bit patterns, then deletes that compact the list
    '{CMD_INSERT, 32'hA5A5A5A5, 24'h555555, 14'h2AAA, 1'b0, NO_WANT},
    '{CMD_INSERT, 32'h5A5A5A5A, 24'hAAAAAA, 14'h1555, 1'b0, NO_WANT},
    '{CMD_DELETE, 32'hFFFFFFFF, 24'h0,      14'h0,    1'b0, NO_WANT},
    '{CMD_SEARCH, 32'hFFFFFFFF, 24'h0,      14'h0,    1'b0, NO_WANT},
    '{CMD_SEARCH, 32'h5A5A5A5A, 24'h0,      14'h0,    1'b0, NO_WANT},
    '{CMD_DELETE, 32'h0,        24'h0,      14'h0,    1'b0, NO_WANT},
    '{CMD_SEARCH, 32'hA5A5A5A5, 24'h0,      14'h0,    1'b0, NO_WANT},
    '{CMD_DELETE, 32'h12345678, 24'h0,      14'h0,    1'b0, NO_WANT},
    '{CMD_UNUSED, 32'hFFFFFFFF, 24'hFFFFFF, 14'h3FFF, 1'b0, NO_WANT},
    '{CMD_SEARCH, 32'h0,        24'h0,      14'h0,    1'b0, NO_WANT}
  };

  // limit per random phase: extremes, limits under the fill level, reset value
  int phase_limits [PHASES] = '{31, 3, 0, 1, 16, 8, 31, 2, 12, 16};

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [CMD_W-1:0]   in_command;
  logic [KEY_W-1:0]   in_key;
  logic [PRICE_W-1:0] in_price;
  logic [TAX_W-1:0]   in_tax_rate;
  logic out_valid, out_ready;
  logic [STAT_W-1:0]  out_status;
  logic [POS_W-1:0]   out_position;
  logic [PRICE_W-1:0] out_price;
  logic [TAX_W-1:0]   out_tax_rate;
  logic [POS_W-1:0]   out_entries_held;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_capacity_limit;

  // shadow of the list contents
  logic [KEY_W-1:0]   shadow_keys   [CAPACITY];
  logic [PRICE_W-1:0] shadow_prices [CAPACITY];
  logic [TAX_W-1:0]   shadow_taxes  [CAPACITY];
  int                 shadow_held;
  int                 shadow_limit;

  list_result_t pending_results [$];
  list_beat_t   cur_beat;
  list_result_t head, got;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  bit  calm;
  int  errors, beats_in, results_out, deepest, quiet_cycles;
  int  status_seen [5];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bounded_keyed_list_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_key             (in_key),
    .in_price           (in_price),
    .in_tax_rate        (in_tax_rate),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_position       (out_position),
    .out_price          (out_price),
    .out_tax_rate       (out_tax_rate),
    .out_entries_held   (out_entries_held),
    .cfg_we             (cfg_we),
    .cfg_capacity_limit (cfg_capacity_limit)
  );

  // apply one command to the shadow list and return the result it gives
  function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] command,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [PRICE_W-1:0] price,
                                                      input logic [TAX_W-1:0] tax_rate);
    list_result_t r;
    int hit;
    int eff;
    r = '0;
    r.status = STAT_NOT_FOUND;
    hit = -1;
    eff = (shadow_limit < CAPACITY) ? shadow_limit : CAPACITY;
    case (command)
      CMD_INSERT: begin
        if (shadow_held < eff) begin
          shadow_keys[shadow_held]   = key;
          shadow_prices[shadow_held] = price;
          shadow_taxes[shadow_held]  = tax_rate;
          shadow_held++;
          r.status = STAT_INSERTED;
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_DELETE: begin
        // last match wins, later entries slide down
        for (int i = 0; i < shadow_held; i++)
          if (shadow_keys[i] == key) hit = i;
        if (hit >= 0) begin
          for (int i = hit; i + 1 < shadow_held; i++) begin
            shadow_keys[i]   = shadow_keys[i + 1];
            shadow_prices[i] = shadow_prices[i + 1];
            shadow_taxes[i]  = shadow_taxes[i + 1];
          end
          shadow_held--;
          r.status = STAT_REMOVED;
        end
      end
      CMD_SEARCH: begin
        // first match wins
        for (int i = 0; i < shadow_held; i++) begin
          if (hit < 0 && shadow_keys[i] == key) begin
            hit        = i;
            r.status   = STAT_FOUND;
            r.position = pos_t'(i + 1);
            r.price    = shadow_prices[i];
            r.tax_rate = shadow_taxes[i];
          end
        end
      end
      default: begin
      end
    endcase
    r.held = pos_t'(shadow_held);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  // result checking first, then prediction, so a result never meets its own beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_out++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, got status %0d",
                   $time, out_status);
          errors++;
        end else begin
          head = pending_results.pop_front();
          check_field("status", 32'(head.status), 32'(out_status));
          check_field("position", 32'(head.position), 32'(out_position));
          check_field("price", 32'(head.price), 32'(out_price));
          check_field("tax rate", 32'(head.tax_rate), 32'(out_tax_rate));
          check_field("entries held", 32'(head.held), 32'(out_entries_held));
          if (int'(head.status) < 5) status_seen[head.status]++;
          if (int'(head.held) > deepest) deepest = head.held;
        end
      end
      if (in_valid && in_ready) begin
        beats_in++;
        got = apply_list_command(cur_beat.command, cur_beat.key, cur_beat.price,
                                 cur_beat.tax_rate);
        pending_results.push_back(cur_beat.typed ? cur_beat.want : got);
      end
    end
  end

  // watchdog on cycles with no beat at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_results.size());
      $display("bounded_keyed_list_top regression: fail");
      $finish;
    end
  end

  // result side: random stall per beat, none in calm phases
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // drive one beat from a falling edge; returns at the falling edge after accept
  task automatic send_beat(input list_beat_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_beat    = b;
    in_valid    <= 1'b1;
    in_command  <= b.command;
    in_key      <= b.key;
    in_price    <= b.price;
    in_tax_rate <= b.tax_rate;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // limit write once everything in flight has come back
  task automatic write_limit(input int value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we             <= 1'b1;
    cfg_capacity_limit <= LIMIT_W'(value);
    shadow_limit       = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly pooled keys so deletes and searches hit; some fresh keys as noise
  function automatic list_beat_t random_beat(input int insert_pct);
    list_beat_t b;
    int r;
    b = '0;
    r = $urandom_range(0, 99);
    if (r < insert_pct)                            b.command = CMD_INSERT;
    else if (r < insert_pct + (95 - insert_pct) / 2) b.command = CMD_DELETE;
    else if (r < 95)                               b.command = CMD_SEARCH;
    else                                           b.command = CMD_UNUSED;
    b.key      = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : KEY_W'($urandom);
    b.price    = PRICE_W'($urandom);
    b.tax_rate = ($urandom_range(0, 9) == 0) ? TAX_W'($urandom)
                                             : TAX_W'($urandom_range(0, 10000));
    return b;
  endfunction

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_command         = '0;
    in_key             = '0;
    in_price           = '0;
    in_tax_rate        = '0;
    cfg_we             = 1'b0;
    cfg_capacity_limit = '0;
    cur_beat           = '0;
    calm               = 1'b0;
    shadow_held        = 0;
    shadow_limit       = int'(LIMIT_RESET);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_table[i]) send_beat(dir_table[i]);

    // random phases, one limit each
    for (int p = 0; p < PHASES; p++) begin
      write_limit(phase_limits[p]);
      calm = (p % 3 == 2);
      foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
      if ($urandom_range(0, 1)) begin
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      for (int n = 0; n < PHASE_BEATS; n++)
        send_beat(random_beat((p % 2 == 0) ? 50 : 30));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain, then a tail wait for anything stray
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("Covered %0d beats in, %0d results out over %0d limit settings; deepest list %0d.",
             beats_in, results_out, PHASES + 1, deepest);
    $display("Outcomes inserted/full/removed/not found/found: %0d/%0d/%0d/%0d/%0d; %0d errors.",
             status_seen[STAT_INSERTED], status_seen[STAT_FULL], status_seen[STAT_REMOVED],
             status_seen[STAT_NOT_FOUND], status_seen[STAT_FOUND], errors);
    if (errors == 0) begin
      $display("bounded_keyed_list_top regression: pass");
    end else begin
      $display("bounded_keyed_list_top regression: fail");
    end
    $finish;
  end

endmodule
